[hw/rtl/aes_pkg.sv]
// package for the escape stripper: payload types, parse modes and byte codes
`default_nettype none
package aes_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } aes_in_t;

  typedef struct packed {
    logic       keep;
    logic [7:0] out_byte;
    logic       out_last;
  } aes_out_t;

  typedef enum logic [5:0] {
    MODE_TEXT    = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_CSI     = 6'b000100,
    MODE_OSC     = 6'b001000,
    MODE_OSC_ESC = 6'b010000,
    MODE_CHARSET = 6'b100000
  } aes_mode_e;

  localparam logic [7:0] ChEsc  = 8'h1B;
  localparam logic [7:0] ChBel  = 8'h07;
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChBsl  = 8'h5C;
  localparam logic [7:0] ChLbrk = 8'h5B;
  localparam logic [7:0] ChRbrk = 8'h5D;
  localparam logic [7:0] ChLpar = 8'h28;
  localparam logic [7:0] ChRpar = 8'h29;
  localparam logic [7:0] CsiLo  = 8'h40;
  localparam logic [7:0] CsiHi  = 8'h7E;

endpackage
`default_nettype wire

[hw/rtl/aes_parser.sv]
// escape sequence parser: next mode and result for one byte
`default_nettype none
module aes_parser (
  input  wire aes_pkg::aes_mode_e mode_i,
  input  wire aes_pkg::aes_in_t   item_i,
  output aes_pkg::aes_mode_e      mode_o,
  output aes_pkg::aes_out_t       result_o
);

  logic [7:0]         b;
  logic               keep;
  aes_pkg::aes_mode_e nxt;
  aes_pkg::aes_mode_e osc_nxt;

  assign b = item_i.in_byte;

  always_comb begin
    if (b == aes_pkg::ChBel) begin
      osc_nxt = aes_pkg::MODE_TEXT;
    end else if (b == aes_pkg::ChEsc) begin
      osc_nxt = aes_pkg::MODE_OSC_ESC;
    end else begin
      osc_nxt = aes_pkg::MODE_OSC;
    end
  end

  always_comb begin
    keep = 1'b0;
    nxt  = aes_pkg::MODE_TEXT;
    case (mode_i)
      aes_pkg::MODE_ESC: begin
        if (b == aes_pkg::ChLbrk) begin
          nxt = aes_pkg::MODE_CSI;
        end else if (b == aes_pkg::ChRbrk) begin
          nxt = aes_pkg::MODE_OSC;
        end else if (b == aes_pkg::ChLpar || b == aes_pkg::ChRpar) begin
          nxt = aes_pkg::MODE_CHARSET;
        end
      end
      aes_pkg::MODE_CSI: begin
        if (!(b >= aes_pkg::CsiLo && b <= aes_pkg::CsiHi)) begin
          nxt = aes_pkg::MODE_CSI;
        end
      end
      aes_pkg::MODE_OSC: begin
        nxt = osc_nxt;
      end
      aes_pkg::MODE_OSC_ESC: begin
        if (b != aes_pkg::ChBsl) begin
          nxt = osc_nxt;
        end
      end
      aes_pkg::MODE_CHARSET: begin
        nxt = aes_pkg::MODE_TEXT;
      end
      default: begin
        // text mode; a trailing esc is passed through
        if (b == aes_pkg::ChEsc) begin
          if (item_i.in_last) begin
            keep = 1'b1;
          end else begin
            nxt = aes_pkg::MODE_ESC;
          end
        end else if (b != aes_pkg::ChBel && b != aes_pkg::ChNul) begin
          keep = 1'b1;
        end
      end
    endcase
  end

  assign mode_o            = item_i.in_last ? aes_pkg::MODE_TEXT : nxt;
  assign result_o.keep     = keep;
  assign result_o.out_byte = keep ? b : 8'h00;
  assign result_o.out_last = item_i.in_last;

endmodule
`default_nettype wire

[hw/rtl/ansi_escape_stripper_top.sv]
// top level of the escape stripper: input register, parser, result register
// Removes terminal escape sequences from a byte stream, one byte per transfer.
// Input channel: in_valid_i / in_stall_o carry in_data_i (byte plus last flag).
// Output channel: out_valid_o / out_stall_i carry out_data_o, one result for
// every input byte: keep flag, byte (zero when dropped) and last flag.
// A byte accepted waits in the input register; the parser derives its result
// combinationally, the result register loads it and drives out_data_o, and the
// parse mode register updates in the same cycle the byte moves from the input
// register to the result register. Throughput: one byte per cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds; the input register
// still takes one more byte, then in_stall_o rises until the result drains.
// After a byte flagged last the parser returns to text mode.
// Reset clears both valid flags and puts the parser in text mode; no byte
// is accepted or presented while rst_ni is low.
`default_nettype none
module ansi_escape_stripper_top (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire aes_pkg::aes_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output aes_pkg::aes_out_t       out_data_o
);

  logic               s1_valid_q, s1_valid_d;
  aes_pkg::aes_in_t   s1_q;
  logic               s2_valid_q, s2_valid_d;
  aes_pkg::aes_out_t  s2_q;
  aes_pkg::aes_mode_e mode_q, mode_d;
  aes_pkg::aes_out_t  result;
  logic               s2_load, s1_move, s1_load;

  aes_parser u_parser (
    .mode_i   (mode_q),
    .item_i   (s1_q),
    .mode_o   (mode_d),
    .result_o (result)
  );

  assign s2_load    = !s2_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !s2_load;

  assign s1_valid_d = s1_load || (s1_valid_q && !s1_move);
  assign s2_valid_d = s1_move || (s2_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      mode_q     <= aes_pkg::MODE_TEXT;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s1_move) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= in_data_i;
    end
    if (s1_move) begin
      s2_q <= result;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

`ifndef SYNTHESIS
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.keep |-> out_data_o.out_byte == 8'h00)
    else $error("dropped byte not zeroed");

  a_last_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && s1_q.in_last |=> mode_q == aes_pkg::MODE_TEXT)
    else $error("parser not back in text mode after last byte");

  a_esc_kept_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.keep && out_data_o.out_byte == aes_pkg::ChEsc
    |-> out_data_o.out_last)
    else $error("escape kept that does not end the string");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && out_stall_i)
    else $error("input stalled while pipeline has room");
`endif

endmodule
`default_nettype wire

[bench/tb_ansi_escape_stripper_top.sv]
// testbench for ansi_escape_stripper_top: random terminal strings checked against a parse model
`timescale 1ns / 1ps
module tb_ansi_escape_stripper_top;

  localparam int RandomBytes   = 1050;
  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles  = 10;

  // tracks the parse mode and the stripped bytes still owed by the block
  class strip_scoreboard;
    aes_pkg::aes_mode_e mode;
    aes_pkg::aes_out_t  owed_q[$];
    int                 errors;
    int                 checked;
    int                 kept;

    function new();
      mode = aes_pkg::MODE_TEXT;
    endfunction

    function aes_pkg::aes_mode_e osc_next(logic [7:0] b);
      if (b == aes_pkg::ChBel) return aes_pkg::MODE_TEXT;
      if (b == aes_pkg::ChEsc) return aes_pkg::MODE_OSC_ESC;
      return aes_pkg::MODE_OSC;
    endfunction

    function void note_byte(aes_pkg::aes_in_t item);
      aes_pkg::aes_mode_e next_mode;
      logic               keep;
      logic [7:0]         b;
      aes_pkg::aes_out_t  res;
      b = item.in_byte;
      keep = 1'b0;
      next_mode = aes_pkg::MODE_TEXT;
      case (mode)
        aes_pkg::MODE_ESC: begin
          if (b == aes_pkg::ChLbrk) next_mode = aes_pkg::MODE_CSI;
          else if (b == aes_pkg::ChRbrk) next_mode = aes_pkg::MODE_OSC;
          else if (b == aes_pkg::ChLpar || b == aes_pkg::ChRpar)
            next_mode = aes_pkg::MODE_CHARSET;
        end
        aes_pkg::MODE_CSI: begin
          if (!(b >= aes_pkg::CsiLo && b <= aes_pkg::CsiHi)) next_mode = aes_pkg::MODE_CSI;
        end
        aes_pkg::MODE_OSC: begin
          next_mode = osc_next(b);
        end
        aes_pkg::MODE_OSC_ESC: begin
          if (b != aes_pkg::ChBsl) next_mode = osc_next(b);
        end
        aes_pkg::MODE_CHARSET: begin
          next_mode = aes_pkg::MODE_TEXT;
        end
        default: begin
          if (b == aes_pkg::ChEsc) begin
            // an escape that ends the string is ordinary text
            if (item.in_last) keep = 1'b1;
            else next_mode = aes_pkg::MODE_ESC;
          end else if (b != aes_pkg::ChBel && b != aes_pkg::ChNul) begin
            keep = 1'b1;
          end
        end
      endcase
      mode = item.in_last ? aes_pkg::MODE_TEXT : next_mode;
      res.keep = keep;
      res.out_byte = keep ? b : 8'h00;
      res.out_last = item.in_last;
      owed_q = {owed_q, res};
    endfunction

    function void check_result(aes_pkg::aes_out_t got);
      aes_pkg::aes_out_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: keep %0d out_byte 0x%02h out_last %0d",
               got.keep, got.out_byte, got.out_last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.keep) kept++;
      if (got.keep !== want.keep) begin
        $error("keep mismatch: expected %0d, actual %0d", want.keep, got.keep);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
               want.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last mismatch: expected %0d, actual %0d", want.out_last, got.out_last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  aes_pkg::aes_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  aes_pkg::aes_out_t out_data_o;

  strip_scoreboard   sb = new();
  aes_pkg::aes_in_t  stim_q[$];
  logic [7:0]        text_q[$];
  int                in_gap_max = 9;
  int                out_gap_max = 9;
  int                bytes_sent;
  int                strings_sent;
  int                idle_cycles;

  ansi_escape_stripper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ends the run when no transfer happens on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      repeat (gap) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  function void push_byte(logic [7:0] b, logic last);
    aes_pkg::aes_in_t item;
    item.in_byte = b;
    item.in_last = last;
    stim_q = {stim_q, item};
  endfunction

  function void add_text(logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  // random terminal string: text mixed with well-formed and broken sequences;
  // cutting it at a random length often ends it inside a sequence
  function void build_string(int len);
    int n;
    text_q.delete();
    while (text_q.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 3) == 0) add_text(8'($urandom_range(0, 255)));
          else add_text(8'($urandom_range(8'h20, 8'h7E)));
        end
        3, 4: begin
          add_text(aes_pkg::ChEsc);
          add_text(aes_pkg::ChLbrk);
          n = $urandom_range(0, 3);
          repeat (n) add_text(8'($urandom_range(8'h20, 8'h3F)));
          if ($urandom_range(0, 7) == 0) add_text(8'($urandom_range(0, 255)));
          add_text(8'($urandom_range(aes_pkg::CsiLo, aes_pkg::CsiHi)));
        end
        5, 6: begin
          add_text(aes_pkg::ChEsc);
          add_text(aes_pkg::ChRbrk);
          n = $urandom_range(0, 4);
          repeat (n) add_text(8'($urandom_range(8'h20, 8'hFF)));
          if ($urandom_range(0, 2) == 0) begin
            // stray escape inside the osc body
            add_text(aes_pkg::ChEsc);
            add_text(8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 1) == 0) begin
            add_text(aes_pkg::ChBel);
          end else begin
            add_text(aes_pkg::ChEsc);
            add_text(aes_pkg::ChBsl);
          end
        end
        7: begin
          add_text(aes_pkg::ChEsc);
          add_text($urandom_range(0, 1) ? aes_pkg::ChLpar : aes_pkg::ChRpar);
          add_text(8'($urandom_range(0, 255)));
        end
        8: begin
          add_text(aes_pkg::ChEsc);
          add_text(8'($urandom_range(0, 255)));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: add_text(aes_pkg::ChEsc);
            1: add_text(aes_pkg::ChBel);
            2: add_text(aes_pkg::ChNul);
            default: add_text(8'($urandom_range(0, 255)));
          endcase
        end
      endcase
    end
    while (text_q.size() > len) void'(text_q.pop_back());
    foreach (text_q[i]) push_byte(text_q[i], i == len - 1);
  endfunction

  task automatic send_byte(aes_pkg::aes_in_t item);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(item);
    bytes_sent++;
  endtask

  task automatic send_queue();
    while (stim_q.size() > 0) send_byte(stim_q.pop_front());
  endtask

  // hold off the sender until every result owed has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // plain text, nul, bel and the top byte value
    push_byte(8'h41, 1'b0);
    push_byte(aes_pkg::ChNul, 1'b0);
    push_byte(aes_pkg::ChBel, 1'b0);
    push_byte(8'hFF, 1'b1);
    // csi color sequence
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(aes_pkg::ChLbrk, 1'b0);
    push_byte(8'h31, 1'b0);
    push_byte(8'h6D, 1'b0);
    // osc ended by bel
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(aes_pkg::ChRbrk, 1'b0);
    push_byte(aes_pkg::ChBel, 1'b0);
    // osc with a stray escape, ended by escape backslash
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(aes_pkg::ChRbrk, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(8'h71, 1'b0);
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(aes_pkg::ChBsl, 1'b0);
    // charset selection, then a plain two-byte escape
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(aes_pkg::ChRpar, 1'b0);
    push_byte(8'h30, 1'b0);
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(8'h63, 1'b0);
    // string ends inside an open csi
    push_byte(aes_pkg::ChEsc, 1'b0);
    push_byte(aes_pkg::ChLbrk, 1'b0);
    push_byte(8'h35, 1'b1);
    // escape as the last byte is kept
    push_byte(aes_pkg::ChEsc, 1'b1);
    send_queue();
    drain();

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
      len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 20);
      build_string(len);
      send_queue();
      strings_sent++;
      if (strings_sent == 40) drain();
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d random bytes in %0d strings after the directed strings",
             bytes_sent, strings_sent);
    $display("Checked %0d results, %0d bytes kept, %0d mismatches",
             sb.checked, sb.kept, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
